>>> hdl/bsa_pkg.sv
// Shared widths and the control record that travels with an item along the
// digit chain of the signed BCD add, subtract, shift and complement unit. No dependencies.
`default_nettype none

package bsa_pkg;

  localparam int FIELD_W = 64;
  localparam int CMD_W   = 3;
  localparam int CNT_W   = 5;
  localparam int KIND_W  = 2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              sign;
    logic              sign_alt;
    logic              ovf;
    logic [CNT_W-1:0]  cnt_a;
    logic              carry_p;
    logic              carry_q;
  } ctl_t;

endpackage

`default_nettype wire

>>> hdl/bsa_if.sv
// Valid/ready channel interfaces for operand and result transfers.
// Depends on bsa_pkg for the field widths.
`default_nettype none

interface bsa_req_if;
  logic                        valid;
  logic                        ready;
  logic [bsa_pkg::CMD_W-1:0]   cmd;
  logic                        a_sign;
  logic [bsa_pkg::FIELD_W-1:0] a_digits;
  logic                        b_sign;
  logic [bsa_pkg::FIELD_W-1:0] b_digits;

  modport source (output valid, cmd, a_sign, a_digits, b_sign, b_digits, input ready);
  modport sink (input valid, cmd, a_sign, a_digits, b_sign, b_digits, output ready);
endinterface

interface bsa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        res_sign;
  logic [bsa_pkg::FIELD_W-1:0] res_digits;
  logic [bsa_pkg::CNT_W-1:0]   digit_count;
  logic                        overflow;

  modport source (output valid, res_sign, res_digits, digit_count, overflow, input ready);
  modport sink (input valid, res_sign, res_digits, digit_count, overflow, output ready);
endinterface

`default_nettype wire

>>> hdl/signed_bcd_add_sub_shift.sv
// Signed BCD add, subtract, shift and complement unit built as a chain of
// digit cells. Depends on bsa_pkg, bsa_if and bsa_cell.
// An operand transfer passes DIGITS registered digit cells, where the decimal
// carry ripples one digit per cell, and then the result register.
// Throughput is one item per cycle while results are taken; a stall does not
// stop the chain until every cell holds an item. Reset clears only valid flags.
`default_nettype none

module signed_bcd_add_sub_shift #(
  parameter int DIGITS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  bsa_req_if.sink    req,
  bsa_rsp_if.source  rsp
);
  import bsa_pkg::*;

  localparam int W = 4 * DIGITS;

  localparam logic [CMD_W-1:0] CMD_ADD   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SUB   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MUL10 = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DIV10 = 3'd3;
  localparam logic [CMD_W-1:0] CMD_COMP  = 3'd4;

  localparam logic [KIND_W-1:0] KIND_ADD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DIFF = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PASS = 2'd2;
  localparam logic [KIND_W-1:0] KIND_COMP = 2'd3;

  function automatic logic [W-1:0] clamp(input logic [W-1:0] v);
    logic [W-1:0] r;
    r = v;
    for (int i = 0; i < DIGITS; i++) begin
      if (v[4*i +: 4] > 4'd9) begin
        r[4*i +: 4] = 4'd9;
      end
    end
    return r;
  endfunction

  function automatic logic [W-1:0] nines(input logic [W-1:0] v);
    logic [W-1:0] r;
    r = '0;
    for (int i = 0; i < DIGITS; i++) begin
      r[4*i +: 4] = 4'd9 - v[4*i +: 4];
    end
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] sig_count(input logic [W-1:0] v);
    logic [CNT_W-1:0] c;
    c = CNT_W'(1);
    for (int i = 1; i < DIGITS; i++) begin
      if (v[4*i +: 4] != 4'd0) begin
        c = CNT_W'(i + 1);
      end
    end
    return c;
  endfunction

  logic         valid_s [DIGITS+1];
  logic         en_s    [DIGITS+1];
  logic [W-1:0] xp_s    [DIGITS+1];
  logic [W-1:0] yp_s    [DIGITS+1];
  logic [W-1:0] xq_s    [DIGITS+1];
  logic [W-1:0] yq_s    [DIGITS+1];
  ctl_t         ctl_s   [DIGITS+1];

  logic [W-1:0] a_cl;
  logic [W-1:0] b_cl;
  logic         b_sign_eff;

  always_comb begin
    a_cl       = clamp(req.a_digits[W-1:0]);
    b_cl       = clamp(req.b_digits[W-1:0]);
    b_sign_eff = req.b_sign ^ (req.cmd == CMD_SUB);
    xp_s[0]    = '0;
    yp_s[0]    = '0;
    xq_s[0]    = '0;
    yq_s[0]    = '0;
    ctl_s[0]   = '0;
    ctl_s[0].kind = KIND_PASS;
    case (req.cmd)
      CMD_ADD, CMD_SUB: begin
        ctl_s[0].sign = req.a_sign;
        if (req.a_sign == b_sign_eff) begin
          ctl_s[0].kind = KIND_ADD;
          xp_s[0] = a_cl;
          yp_s[0] = b_cl;
        end else begin
          ctl_s[0].kind     = KIND_DIFF;
          ctl_s[0].sign_alt = b_sign_eff;
          ctl_s[0].carry_p  = 1'b1;
          ctl_s[0].carry_q  = 1'b1;
          xp_s[0] = a_cl;
          yp_s[0] = nines(b_cl);
          xq_s[0] = b_cl;
          yq_s[0] = nines(a_cl);
        end
      end
      CMD_MUL10: begin
        ctl_s[0].sign = req.a_sign;
        ctl_s[0].ovf  = (a_cl[W-1 -: 4] != 4'd0);
        xp_s[0] = a_cl << 4;
      end
      CMD_DIV10: begin
        ctl_s[0].sign = req.a_sign;
        xp_s[0] = a_cl >> 4;
      end
      CMD_COMP: begin
        if (req.a_sign) begin
          ctl_s[0].kind    = KIND_COMP;
          ctl_s[0].sign    = 1'b1;
          ctl_s[0].carry_p = 1'b1;
          ctl_s[0].cnt_a   = sig_count(a_cl);
          yp_s[0] = nines(a_cl);
        end else begin
          xp_s[0] = a_cl;
        end
      end
      default: begin
        xp_s[0] = '0;
      end
    endcase
  end

  assign valid_s[0] = req.valid;
  assign req.ready  = en_s[0];

  for (genvar g = 0; g < DIGITS; g++) begin : g_cell
    bsa_cell #(
      .DIGITS (DIGITS),
      .IDX    (g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (valid_s[g]),
      .up_xp    (xp_s[g]),
      .up_yp    (yp_s[g]),
      .up_xq    (xq_s[g]),
      .up_yq    (yq_s[g]),
      .up_ctl   (ctl_s[g]),
      .up_en    (en_s[g]),
      .dn_en    (en_s[g+1]),
      .dn_valid (valid_s[g+1]),
      .dn_xp    (xp_s[g+1]),
      .dn_yp    (yp_s[g+1]),
      .dn_xq    (xq_s[g+1]),
      .dn_yq    (yq_s[g+1]),
      .dn_ctl   (ctl_s[g+1])
    );
  end

  logic             out_valid;
  logic             out_sign;
  logic [W-1:0]     out_digits;
  logic [CNT_W-1:0] out_count;
  logic             out_ovf;

  logic             fin_sign;
  logic [W-1:0]     fin_digits;
  logic [CNT_W-1:0] fin_count;
  logic             fin_ovf;
  ctl_t             last;

  always_comb begin
    last       = ctl_s[DIGITS];
    fin_digits = xp_s[DIGITS];
    fin_sign   = last.sign;
    fin_ovf    = 1'b0;
    case (last.kind)
      KIND_ADD: begin
        fin_ovf = last.carry_p;
      end
      KIND_DIFF: begin
        if (!last.carry_p) begin
          fin_digits = xq_s[DIGITS];
          fin_sign   = last.sign_alt;
        end
      end
      KIND_PASS: begin
        fin_ovf = last.ovf;
      end
      default: begin
        fin_ovf = 1'b0;
      end
    endcase
    if (last.kind == KIND_COMP) begin
      fin_count = last.cnt_a;
    end else begin
      fin_count = sig_count(fin_digits);
    end
    if (fin_digits == '0) begin
      fin_sign  = 1'b0;
      fin_count = CNT_W'(1);
    end
  end

  assign en_s[DIGITS] = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_s[DIGITS]) begin
      out_valid <= valid_s[DIGITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en_s[DIGITS]) begin
      out_sign   <= fin_sign;
      out_digits <= fin_digits;
      out_count  <= fin_count;
      out_ovf    <= fin_ovf;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.res_sign    = out_sign;
  assign rsp.res_digits  = FIELD_W'(out_digits);
  assign rsp.digit_count = out_count;
  assign rsp.overflow    = out_ovf;

  a_zero_is_plus: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_digits == '0) |-> !out_sign && (out_count == CNT_W'(1)))
    else $error("Zero result must be +0 with one digit.");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_count != '0) && (out_count <= CNT_W'(DIGITS)))
    else $error("Digit count out of range.");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("Result valid straight after reset.");

  a_full_backpressure: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> req.ready)
    else $error("Input stalled while the result register is empty.");

endmodule

`default_nettype wire

>>> hdl/bsa_cell.sv
// One digit cell of the carry chain: adds digit IDX of two BCD chains and
// registers the item for the next cell. Depends on bsa_pkg.
`default_nettype none

module bsa_cell #(
  parameter int DIGITS = 16,
  parameter int IDX    = 0
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  up_valid,
  input  wire logic [4*DIGITS-1:0]   up_xp,
  input  wire logic [4*DIGITS-1:0]   up_yp,
  input  wire logic [4*DIGITS-1:0]   up_xq,
  input  wire logic [4*DIGITS-1:0]   up_yq,
  input  wire bsa_pkg::ctl_t         up_ctl,
  output logic                       up_en,
  input  wire logic                  dn_en,
  output logic                       dn_valid,
  output logic [4*DIGITS-1:0]        dn_xp,
  output logic [4*DIGITS-1:0]        dn_yp,
  output logic [4*DIGITS-1:0]        dn_xq,
  output logic [4*DIGITS-1:0]        dn_yq,
  output bsa_pkg::ctl_t              dn_ctl
);
  import bsa_pkg::*;

  logic [4:0]          sum_p;
  logic [4:0]          sum_q;
  logic                cy_p;
  logic                cy_q;
  logic [3:0]          dig_p;
  logic [3:0]          dig_q;
  logic [4*DIGITS-1:0] xp_next;
  logic [4*DIGITS-1:0] xq_next;
  ctl_t                ctl_next;

  always_comb begin
    sum_p = 5'(up_xp[4*IDX +: 4]) + 5'(up_yp[4*IDX +: 4]) + 5'(up_ctl.carry_p);
    sum_q = 5'(up_xq[4*IDX +: 4]) + 5'(up_yq[4*IDX +: 4]) + 5'(up_ctl.carry_q);
    cy_p  = (sum_p >= 5'd10);
    cy_q  = (sum_q >= 5'd10);
    dig_p = cy_p ? 4'(sum_p - 5'd10) : sum_p[3:0];
    dig_q = cy_q ? 4'(sum_q - 5'd10) : sum_q[3:0];
    xp_next = up_xp;
    xq_next = up_xq;
    xp_next[4*IDX +: 4] = dig_p;
    xq_next[4*IDX +: 4] = dig_q;
    ctl_next = up_ctl;
    ctl_next.carry_p = cy_p;
    ctl_next.carry_q = cy_q;
  end

  assign up_en = !dn_valid || dn_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_en) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_en) begin
      dn_xp  <= xp_next;
      dn_yp  <= up_yp;
      dn_xq  <= xq_next;
      dn_yq  <= up_yq;
      dn_ctl <= ctl_next;
    end
  end

endmodule

`default_nettype wire

>>> verif/tb_signed_bcd_add_sub_shift.sv
// Self-checking testbench for the signed BCD add, subtract, shift and complement unit.
// Depends on bsa_pkg, bsa_req_if, bsa_rsp_if and signed_bcd_add_sub_shift.
// Random valid/ready traffic on both channels is checked against a built-in decimal predictor.
`default_nettype none

module tb_signed_bcd_add_sub_shift;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIGITS = 16;
  localparam int MAG_W = 4 * DIGITS;
  localparam int RANDOM_OPS = 650;
  localparam int HOLD_AT = 450;
  localparam int HOLD_CYCLES = 80;

  typedef enum logic [bsa_pkg::CMD_W-1:0] {
    CMD_ADD, CMD_SUB, CMD_MUL10, CMD_DIV10, CMD_CPL, CMD_RSV5, CMD_RSV6, CMD_RSV7
  } op_code_e;

  typedef logic [MAG_W-1:0] mag_t;

  typedef struct packed {
    op_code_e                    cmd;
    logic                        a_sign;
    logic [bsa_pkg::FIELD_W-1:0] a_digits;
    logic                        b_sign;
    logic [bsa_pkg::FIELD_W-1:0] b_digits;
  } op_t;

  typedef struct packed {
    logic                        sign;
    logic [bsa_pkg::FIELD_W-1:0] digits;
    logic [bsa_pkg::CNT_W-1:0]   count;
    logic                        ovf;
  } res_t;

  logic clk;
  logic rst;

  bsa_req_if req_ch ();
  bsa_rsp_if rsp_ch ();

  signed_bcd_add_sub_shift #(.DIGITS(DIGITS)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  op_t  pending_ops_q[$];
  res_t due_results_q[$];
  op_t  cur_op;
  int   sent_cnt;
  int   total_ops;
  int   checked_cnt;
  int   fail_cnt;
  int   op_mix[8];
  int   stall_left;
  bit   stall_done;
  logic steady;

  assign steady = (sent_cnt >= 250) && (sent_cnt < 400);

  function automatic mag_t clamp_bcd(logic [bsa_pkg::FIELD_W-1:0] v);
    mag_t m;
    for (int i = 0; i < DIGITS; i++) begin
      m[4*i +: 4] = (v[4*i +: 4] > 4'd9) ? 4'd9 : v[4*i +: 4];
    end
    return m;
  endfunction

  function automatic int sig_digits(mag_t m);
    for (int i = DIGITS - 1; i > 0; i--) begin
      if (m[4*i +: 4] != 4'd0) return i + 1;
    end
    return 1;
  endfunction

  // Digit-serial decimal sum; with nines set, y is nines-complemented and a carry of one enters.
  function automatic mag_t bcd_sum(mag_t x, mag_t y, bit nines, output bit carry);
    mag_t r;
    int   s;
    int   c;
    c = int'(nines);
    for (int i = 0; i < DIGITS; i++) begin
      s = int'(x[4*i +: 4]) + (nines ? 9 - int'(y[4*i +: 4]) : int'(y[4*i +: 4])) + c;
      c = (s >= 10) ? 1 : 0;
      r[4*i +: 4] = 4'(c ? s - 10 : s);
    end
    carry = 1'(c);
    return r;
  endfunction

  function automatic res_t decimal_result(op_t op);
    res_t res;
    mag_t a;
    mag_t b;
    mag_t r;
    logic bs;
    bit   carry;
    bit   cnt_fixed;
    a = clamp_bcd(op.a_digits);
    b = clamp_bcd(op.b_digits);
    r = '0;
    bs = op.b_sign;
    cnt_fixed = 1'b0;
    res = '0;
    case (op.cmd)
      CMD_ADD, CMD_SUB: begin
        if (op.cmd == CMD_SUB) bs = ~bs;
        if (op.a_sign == bs) begin
          r = bcd_sum(a, b, 1'b0, carry);
          res.ovf = carry;
          res.sign = op.a_sign;
        end else if (a > b) begin
          r = bcd_sum(a, b, 1'b1, carry);
          res.sign = op.a_sign;
        end else if (b > a) begin
          r = bcd_sum(b, a, 1'b1, carry);
          res.sign = bs;
        end
      end
      CMD_MUL10: begin
        res.ovf = (a[MAG_W-1 -: 4] != 4'd0);
        r = a << 4;
        res.sign = op.a_sign;
      end
      CMD_DIV10: begin
        if (sig_digits(a) > 1) begin
          r = a >> 4;
          res.sign = op.a_sign;
        end
      end
      CMD_CPL: begin
        if (!op.a_sign) begin
          r = a;
        end else begin
          r = bcd_sum('0, a, 1'b1, carry);
          res.sign = 1'b1;
          res.count = bsa_pkg::CNT_W'(sig_digits(a));
          cnt_fixed = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (r == '0) begin
      res.sign = 1'b0;
      res.count = bsa_pkg::CNT_W'(1);
    end else if (!cnt_fixed) begin
      res.count = bsa_pkg::CNT_W'(sig_digits(r));
    end
    res.digits = bsa_pkg::FIELD_W'(r);
    return res;
  endfunction

  function automatic logic [bsa_pkg::FIELD_W-1:0] rand_mag();
    logic [bsa_pkg::FIELD_W-1:0] v;
    int len;
    int style;
    style = $urandom_range(0, 9);
    if (style == 0) return {$urandom, $urandom};
    len = (style < 4) ? $urandom_range(1, 4) : $urandom_range(1, DIGITS);
    v = '0;
    for (int i = 0; i < len; i++) begin
      v[4*i +: 4] = (style == 1) ? 4'd9 : 4'($urandom_range(0, 9));
    end
    return v;
  endfunction

  task automatic queue_op(op_code_e cmd, logic as, logic [63:0] ad, logic bs, logic [63:0] bd);
    op_t op;
    op.cmd = cmd;
    op.a_sign = as;
    op.a_digits = ad;
    op.b_sign = bs;
    op.b_digits = bd;
    pending_ops_q.push_back(op);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    bit fire;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      fire = req_ch.valid && req_ch.ready;
      if (fire) begin
        due_results_q.push_back(decimal_result(cur_op));
        op_mix[cur_op.cmd]++;
        sent_cnt <= sent_cnt + 1;
      end
      if (fire || !req_ch.valid) begin
        if (pending_ops_q.size() > 0 && (steady || $urandom_range(0, 99) >= 35)) begin
          cur_op = pending_ops_q.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.cmd <= cur_op.cmd;
          req_ch.a_sign <= cur_op.a_sign;
          req_ch.a_digits <= cur_op.a_digits;
          req_ch.b_sign <= cur_op.b_sign;
          req_ch.b_digits <= cur_op.b_digits;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Once, well into the run, the result side holds off long enough to back up the whole chain.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left <= 0;
      stall_done <= 1'b0;
    end else if (!stall_done && sent_cnt >= HOLD_AT) begin
      rsp_ch.ready <= 1'b0;
      stall_left <= HOLD_CYCLES;
      stall_done <= 1'b1;
    end else if (stall_left > 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 35);
    end
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.sign = rsp_ch.res_sign;
      got.digits = rsp_ch.res_digits;
      got.count = rsp_ch.digit_count;
      got.ovf = rsp_ch.overflow;
      checked_cnt++;
      if (due_results_q.size() == 0) begin
        if (fail_cnt < 10) begin
          $display("Unexpected result transfer: sign %0b digits %h count %0d overflow %0b",
                   got.sign, got.digits, got.count, got.ovf);
        end
        fail_cnt++;
      end else begin
        want = due_results_q.pop_front();
        if (got.sign !== want.sign || got.digits !== want.digits ||
            got.count !== want.count || got.ovf !== want.ovf) begin
          if (fail_cnt < 10) begin
            $display("Result mismatch: expected sign %0b digits %h count %0d overflow %0b",
                     want.sign, want.digits, want.count, want.ovf);
            $display("                 actual   sign %0b digits %h count %0d overflow %0b",
                     got.sign, got.digits, got.count, got.ovf);
          end
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    op_code_e    cmd;
    logic [63:0] a;
    logic [63:0] b;
    int          pick;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_ADD;
    req_ch.a_sign = 1'b0;
    req_ch.a_digits = '0;
    req_ch.b_sign = 1'b0;
    req_ch.b_digits = '0;
    rsp_ch.ready = 1'b0;
    sent_cnt = 0;
    checked_cnt = 0;
    fail_cnt = 0;

    queue_op(CMD_ADD, 1'b0, 64'h0, 1'b0, 64'h0);
    queue_op(CMD_ADD, 1'b0, 64'h9999_9999_9999_9999, 1'b0, 64'h1);
    queue_op(CMD_ADD, 1'b1, 64'h9999_9999_9999_9999, 1'b1, 64'h2);
    queue_op(CMD_ADD, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_op(CMD_ADD, 1'b0, 64'h123, 1'b1, 64'h4567);
    queue_op(CMD_ADD, 1'b1, 64'h5000, 1'b0, 64'h4999);
    queue_op(CMD_SUB, 1'b0, 64'h12345, 1'b0, 64'h12345);
    queue_op(CMD_SUB, 1'b1, 64'h777, 1'b1, 64'h777);
    queue_op(CMD_SUB, 1'b0, 64'h1, 1'b0, 64'h9999_9999_9999_9999);
    queue_op(CMD_SUB, 1'b1, 64'hABCD, 1'b0, 64'h1);
    queue_op(CMD_MUL10, 1'b1, 64'h1234_5678_9012_3456, 1'b0, 64'h0);
    queue_op(CMD_MUL10, 1'b0, 64'h0999_9999_9999_9999, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_op(CMD_MUL10, 1'b1, 64'h0, 1'b0, 64'h0);
    queue_op(CMD_DIV10, 1'b1, 64'h7, 1'b0, 64'h0);
    queue_op(CMD_DIV10, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0);
    queue_op(CMD_DIV10, 1'b0, 64'h10, 1'b0, 64'h0);
    queue_op(CMD_CPL, 1'b0, 64'h9876_5432_1098_7654, 1'b0, 64'h0);
    queue_op(CMD_CPL, 1'b1, 64'h1200, 1'b0, 64'h0);
    queue_op(CMD_CPL, 1'b1, 64'h0, 1'b0, 64'h0);
    queue_op(CMD_CPL, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0);
    queue_op(CMD_CPL, 1'b1, 64'h1, 1'b0, 64'h0);
    queue_op(CMD_RSV5, 1'b1, 64'h5555, 1'b1, 64'h5555);
    queue_op(CMD_RSV6, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_op(CMD_RSV7, 1'b1, 64'h9, 1'b0, 64'h1);

    for (int n = 0; n < RANDOM_OPS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) cmd = CMD_ADD;
      else if (pick < 70) cmd = CMD_SUB;
      else if (pick < 80) cmd = CMD_MUL10;
      else if (pick < 88) cmd = CMD_DIV10;
      else if (pick < 96) cmd = CMD_CPL;
      else cmd = op_code_e'(CMD_RSV5 + $urandom_range(0, 2));
      a = rand_mag();
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        b = a;
      end else if (pick == 1) begin
        for (int i = 0; i < DIGITS; i++) begin
          b[4*i +: 4] = (a[4*i +: 4] > 4'd9) ? 4'd0 : 4'd9 - a[4*i +: 4];
        end
      end else begin
        b = rand_mag();
      end
      queue_op(cmd, 1'($urandom_range(0, 1)), a, 1'($urandom_range(0, 1)), b);
    end
    total_ops = pending_ops_q.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    wait (sent_cnt == total_ops && due_results_q.size() == 0);
    repeat (DIGITS + 10) @(posedge clk);

    $display("Sent %0d operations: %0d add, %0d subtract, %0d times ten, %0d divide by ten,",
             sent_cnt, op_mix[CMD_ADD], op_mix[CMD_SUB], op_mix[CMD_MUL10], op_mix[CMD_DIV10]);
    $display("%0d complement, %0d unused codes; %0d results compared, %0d mismatches.",
             op_mix[CMD_CPL], op_mix[CMD_RSV5] + op_mix[CMD_RSV6] + op_mix[CMD_RSV7],
             checked_cnt, fail_cnt);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
